// ===== src/lrb_pkg.sv =====
// Shared types and constants for the last-lines ring buffer.
`default_nettype none

package lrb_pkg;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [4:0] TAIL_RESET   = 5'd10;

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_BYTE     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		status_t    status;
		logic       last;
	} rsp_t;

endpackage

`default_nettype wire

// ===== src/lrb_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none

module lrb_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/last_lines_ring_buffer_core.sv =====
// Top level of the last-lines ring buffer: sequencer, pointers and the two memories.
//
// Usage:
//   A command (cmd.op, cmd.data_byte) is taken at a rising edge where start is high
//   and busy is low. An append stores the byte in the circular byte memory and
//   tracks line starts; a read returns the next byte of the kept tail, with
//   rsp.last marking the final one, after which the capture clears.
//   Every command gives exactly one response on rsp, marked by done for a single
//   cycle; the receiver cannot hold it off and must take it then.
//   The response appears in the cycle after acceptance, and busy is high during
//   that cycle, so a new command is not taken until the response is given. This
//   is set by the registered read data of the byte and line-start memories: a read
//   needs the stored byte, and an append that drops the oldest line needs the next
//   line start before the overflow compare.
//   tail_lines is written through cfg_we/cfg_data, only while idle (the user's duty;
//   the block does not enforce it); a write also empties the capture and clears any overflow.
//   After reset the capture is empty and tail_lines is 10. No memory clearing pass
//   is run: the line-start cache register stands in for the reset entry, and the
//   drain never reaches byte entries that were not written.
//   Once an overflow is reported every command answers overflow until reset or a
//   configuration write.
`default_nettype none

module last_lines_ring_buffer_core
	import lrb_pkg::*;
#(
	parameter int BUF_BYTES  = 4096,
	parameter int LINE_SLOTS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire cmd_t       cmd,
	output logic            done,
	output rsp_t            rsp,
	input  wire logic       cfg_we,
	input  wire logic [4:0] cfg_data
);

	localparam int AW = $clog2(BUF_BYTES);
	localparam int SW = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
	localparam int NW = SW + 1;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RESP = 2'b10
	} fsm_t;

	fsm_t fsm_q, fsm_d;

	logic [4:0]    tail_q, tail_d;
	logic [AW-1:0] wc_q, wc_d, rc_q, rc_d, ostart_q, ostart_d;
	logic [SW-1:0] oldest_q, oldest_d, newest_q, newest_d;
	logic          prev_nl_q, prev_nl_d;
	logic          ovf_q, ovf_d;
	logic          drain_q, drain_d;
	logic          clr;

	// Pipeline register between acceptance and response.
	status_t status_s1, status_d;
	logic    last_s1, last_d;
	logic    use_rdata_s1, use_rdata_d;
	logic    chk_ovf_s1, chk_ovf_d;
	logic    sel_mem_s1, sel_mem_d;

	logic [NW-1:0] ring_n;
	logic [AW-1:0] wc_e, rc_e, next_rc;
	logic [SW-1:0] oldest_e, newest_e, newest_n, oldest_n;
	logic          prev_nl_e;
	logic [AW-1:0] ostart_e, ostart_chk;
	logic          ovf_hit;

	logic          bwe, bre, lwe, lre;
	logic [AW-1:0] bwaddr, braddr;
	logic [7:0]    bwdata, brdata;
	logic [SW-1:0] lwaddr, lraddr;
	logic [AW-1:0] lwdata, lrdata;

	function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
		return (a == AW'(BUF_BYTES - 1)) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] i,
			input logic [NW-1:0] n);
		return (({1'b0, i} + 1'b1) >= n) ? '0 : i + 1'b1;
	endfunction

	lrb_ram #(.DEPTH(BUF_BYTES), .WIDTH(8)) u_byte_ram (
		.clk   (clk),
		.we    (bwe),
		.waddr (bwaddr),
		.wdata (bwdata),
		.re    (bre),
		.raddr (braddr),
		.rdata (brdata)
	);

	lrb_ram #(.DEPTH(LINE_SLOTS), .WIDTH(AW)) u_line_ram (
		.clk   (clk),
		.we    (lwe),
		.waddr (lwaddr),
		.wdata (lwdata),
		.re    (lre),
		.raddr (lraddr),
		.rdata (lrdata)
	);

	assign ring_n = (32'(tail_q) > LINE_SLOTS) ? NW'(LINE_SLOTS) : NW'(tail_q);

	// An append during a drain first empties the capture.
	assign wc_e      = drain_q ? '0 : wc_q;
	assign oldest_e  = drain_q ? '0 : oldest_q;
	assign newest_e  = drain_q ? '0 : newest_q;
	assign prev_nl_e = drain_q ? 1'b0 : prev_nl_q;
	assign ostart_e  = drain_q ? '0 : ostart_q;
	assign rc_e      = drain_q ? rc_q : ostart_q;
	assign next_rc   = next_addr(rc_e);
	assign newest_n  = next_slot(newest_e, ring_n);
	assign oldest_n  = next_slot(oldest_e, ring_n);

	assign ostart_chk = sel_mem_s1 ? lrdata : ostart_q;
	assign ovf_hit    = (fsm_q == S_RESP) && chk_ovf_s1 && (wc_q == ostart_chk);

	always_comb begin
		fsm_d       = fsm_q;
		tail_d      = tail_q;
		wc_d        = wc_q;
		rc_d        = rc_q;
		ostart_d    = ostart_q;
		oldest_d    = oldest_q;
		newest_d    = newest_q;
		prev_nl_d   = prev_nl_q;
		ovf_d       = ovf_q;
		drain_d     = drain_q;
		clr         = 1'b0;
		status_d    = status_s1;
		last_d      = last_s1;
		use_rdata_d = use_rdata_s1;
		chk_ovf_d   = chk_ovf_s1;
		sel_mem_d   = sel_mem_s1;
		bwe         = 1'b0;
		bwaddr      = wc_e;
		bwdata      = cmd.data_byte;
		bre         = 1'b0;
		braddr      = rc_e;
		lwe         = 1'b0;
		lwaddr      = newest_n;
		lwdata      = wc_e;
		lre         = 1'b0;
		lraddr      = oldest_n;

		if (cfg_we) begin
			tail_d = cfg_data;
			clr    = 1'b1;
		end else begin
			unique case (fsm_q)
				S_IDLE: begin
					if (start) begin
						fsm_d       = S_RESP;
						status_d    = ST_ACCEPTED;
						last_d      = 1'b0;
						use_rdata_d = 1'b0;
						chk_ovf_d   = 1'b0;
						sel_mem_d   = 1'b0;
						if (ovf_q) begin
							status_d = ST_OVERFLOW;
						end else if (cmd.op == OP_APPEND) begin
							wc_d      = wc_e;
							rc_d      = drain_q ? '0 : rc_q;
							ostart_d  = ostart_e;
							oldest_d  = oldest_e;
							newest_d  = newest_e;
							prev_nl_d = prev_nl_e;
							drain_d   = 1'b0;
							if (ring_n != '0) begin
								if (prev_nl_e) begin
									newest_d = newest_n;
									lwe      = 1'b1;
									if (newest_n == oldest_e) begin
										oldest_d = oldest_n;
										// With a single slot the new oldest line is the one
										// just started, so the start is known already.
										if (oldest_n == newest_n) begin
											ostart_d = wc_e;
										end else begin
											lre       = 1'b1;
											sel_mem_d = 1'b1;
										end
									end
								end
								bwe       = 1'b1;
								prev_nl_d = (cmd.data_byte == NEWLINE_CODE);
								wc_d      = next_addr(wc_e);
								chk_ovf_d = 1'b1;
							end
						end else if (ring_n == '0) begin
							status_d = ST_EMPTY;
						end else if (rc_e == wc_q) begin
							status_d = ST_EMPTY;
							clr      = 1'b1;
						end else begin
							bre         = 1'b1;
							use_rdata_d = 1'b1;
							status_d    = ST_BYTE;
							if (next_rc == wc_q) begin
								last_d = 1'b1;
								clr    = 1'b1;
							end else begin
								drain_d = 1'b1;
								rc_d    = next_rc;
							end
						end
					end
				end
				S_RESP: begin
					fsm_d = S_IDLE;
					if (chk_ovf_s1 && sel_mem_s1) begin
						ostart_d = lrdata;
					end
					if (ovf_hit) begin
						ovf_d = 1'b1;
					end
				end
				default: begin
					fsm_d = S_IDLE;
				end
			endcase
		end

		if (clr) begin
			wc_d      = '0;
			rc_d      = '0;
			ostart_d  = '0;
			oldest_d  = '0;
			newest_d  = '0;
			prev_nl_d = 1'b0;
			ovf_d     = 1'b0;
			drain_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= S_IDLE;
			tail_q    <= TAIL_RESET;
			wc_q      <= '0;
			rc_q      <= '0;
			ostart_q  <= '0;
			oldest_q  <= '0;
			newest_q  <= '0;
			prev_nl_q <= 1'b0;
			ovf_q     <= 1'b0;
			drain_q   <= 1'b0;
		end else begin
			fsm_q     <= fsm_d;
			tail_q    <= tail_d;
			wc_q      <= wc_d;
			rc_q      <= rc_d;
			ostart_q  <= ostart_d;
			oldest_q  <= oldest_d;
			newest_q  <= newest_d;
			prev_nl_q <= prev_nl_d;
			ovf_q     <= ovf_d;
			drain_q   <= drain_d;
		end
	end

	always_ff @(posedge clk) begin
		status_s1    <= status_d;
		last_s1      <= last_d;
		use_rdata_s1 <= use_rdata_d;
		chk_ovf_s1   <= chk_ovf_d;
		sel_mem_s1   <= sel_mem_d;
	end

	assign busy         = (fsm_q != S_IDLE);
	assign done         = (fsm_q == S_RESP);
	assign rsp.out_byte = use_rdata_s1 ? brdata : 8'd0;
	assign rsp.status   = ovf_hit ? ST_OVERFLOW : status_s1;
	assign rsp.last     = last_s1;

	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !cfg_we |=> done)
		else $error("accepted transaction gave no response in the next cycle");

	a_idle_after_resp: assert property (@(posedge clk) disable iff (!arst_n)
		done && !cfg_we |=> !busy)
		else $error("sequencer did not return to idle after a response");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q && !cfg_we |=> ovf_q)
		else $error("overflow flag cleared without a configuration write");

	a_last_is_byte: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.last |-> rsp.status == ST_BYTE)
		else $error("last flag raised on a response that returns no byte");

	a_oldest_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		ring_n != '0 |-> {1'b0, oldest_q} < ring_n)
		else $error("oldest line index outside the ring");

endmodule

`default_nettype wire
